FILE: rtl/core/sprite_line_renderer_unit_defines.svh
// assertion macros shared by the sprite line renderer modules
`ifndef SPRITE_LINE_RENDERER_UNIT_DEFINES_SVH
`define SPRITE_LINE_RENDERER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SLR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("slr assertion failed");

// antecedent implies consequent in the next cycle
`define SLR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("slr assertion failed");

`endif

FILE: rtl/core/slr_pkg.sv
// types and constants of the sprite line renderer
package slr_pkg;

    localparam logic [5:0] REG_GRAPHIC_A = 6'h1B;
    localparam logic [5:0] REG_GRAPHIC_B = 6'h1C;
    localparam logic [5:0] REG_DELAY_A   = 6'h25;
    localparam logic [5:0] REG_DELAY_B   = 6'h26;
    localparam logic [5:0] REG_RESET_A   = 6'h10;
    localparam logic [5:0] REG_RESET_B   = 6'h11;
    localparam logic [5:0] REG_MOTION_A  = 6'h20;
    localparam logic [5:0] REG_MOTION_B  = 6'h21;
    localparam logic [5:0] REG_MOVE      = 6'h2A;
    localparam logic [5:0] REG_MOVE_CLR  = 6'h2B;

    localparam int LINE_START    = 68;
    localparam int LINE_PIXELS   = 160;
    localparam int STROBE_OFFSET = 5;
    localparam int STROBE_TAIL   = 3;
    localparam int COPY_SPACING  = 16;
    localparam int COPY_COUNT    = 3;
    localparam int WORD_W        = 64;
    localparam int EVENT_W       = 22;

    localparam logic [7:0] LAST_X    = 8'd159;
    localparam logic [1:0] LAST_WORD = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic       store;      // buffer the accepted write
        logic       read;       // fetch the entry at the replay pointer
        logic       apply;      // apply the fetched entry
        logic       tail;       // apply happens after the visible pixels
        logic       draw;       // shift in the pixel at x
        logic       rewind;     // empty the buffer, reset replay pointer
        logic       shift_out;  // drop the word that was just delivered
        logic [7:0] x;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pending;  // replay pointer below the fill count
        logic due;      // fetched entry lands at or before pixel x
    } sts_t;

endpackage

FILE: rtl/core/slr_ram.sv
// generic single-port-write, registered-read memory
module slr_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/slr_ctrl.sv
// sequencer of the sprite line renderer: buffering, replay, draw and word output
`include "sprite_line_renderer_unit_defines.svh"

module slr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_op,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [1:0]    m_word_index,
    output logic          m_last,
    output slr_pkg::cmd_t cmd,
    input  slr_pkg::sts_t sts
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FETCH  = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_TFETCH = 3'd3;
    localparam logic [2:0] ST_TAPPLY = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [7:0] x_reg, x_next;
    logic [1:0] word_reg, word_next;
    logic       fire;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_OUT);
    assign m_word_index = word_reg;
    assign m_last       = (word_reg == slr_pkg::LAST_WORD);
    assign fire         = sts.pending && sts.due;

    always_comb begin
        state_next    = state_reg;
        x_next        = x_reg;
        word_next     = word_reg;
        cmd           = '0;
        cmd.x         = x_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.store = s_valid && !s_op;
                if (s_valid && s_op) begin
                    x_next     = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.read   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (fire) begin
                    cmd.apply  = 1'b1;
                    state_next = ST_FETCH;
                end else begin
                    cmd.draw = 1'b1;
                    if (x_reg == slr_pkg::LAST_X) begin
                        state_next = ST_TFETCH;
                    end else begin
                        x_next = x_reg + 8'd1;
                    end
                end
            end
            ST_TFETCH: begin
                if (sts.pending) begin
                    cmd.read   = 1'b1;
                    state_next = ST_TAPPLY;
                end else begin
                    cmd.rewind = 1'b1;
                    word_next  = '0;
                    state_next = ST_OUT;
                end
            end
            ST_TAPPLY: begin
                cmd.apply  = 1'b1;
                cmd.tail   = 1'b1;
                state_next = ST_TFETCH;
            end
            ST_OUT: begin
                if (m_ready) begin
                    cmd.shift_out = 1'b1;
                    if (word_reg == slr_pkg::LAST_WORD) begin
                        state_next = ST_IDLE;
                    end else begin
                        word_next = word_reg + 2'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            x_reg     <= '0;
            word_reg  <= '0;
        end else begin
            state_reg <= state_next;
            x_reg     <= x_next;
            word_reg  <= word_next;
        end
    end

    `SLR_ASSERT_NOW(a_one_item, aclk, aresetn, m_valid, !s_ready)
    `SLR_ASSERT_NEXT(a_row_done, aclk, aresetn,
        (state_reg == ST_CHECK) && (x_reg == slr_pkg::LAST_X) && !fire,
        state_reg == ST_TFETCH)
    `SLR_ASSERT_NEXT(a_last_word, aclk, aresetn, m_valid && m_ready && m_last,
        s_ready)
    `SLR_ASSERT_NOW(a_word_range, aclk, aresetn, m_valid,
        m_word_index <= slr_pkg::LAST_WORD)

endmodule

FILE: rtl/core/slr_dp.sv
// datapath: write buffer, player state, pixel test and row register
`include "sprite_line_renderer_unit_defines.svh"

module slr_dp #(
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [5:0]    s_reg_req,
    input  logic [7:0]    s_value,
    input  logic [7:0]    s_clock_req,
    input  slr_pkg::cmd_t cmd,
    output slr_pkg::sts_t sts,
    output logic [63:0]   m_pixels
);

    localparam int ROW_W = slr_pkg::LINE_PIXELS;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] e_reg, e_next;
    logic [7:0]    gna_reg, gna_next, gsa_reg, gsa_next;
    logic [7:0]    gnb_reg, gnb_next, gsb_reg, gsb_next;
    logic          dla_reg, dla_next, dlb_reg, dlb_next;
    logic [7:0]    posa_reg, posa_next, posb_reg, posb_next;
    logic [3:0]    mota_reg, mota_next, motb_reg, motb_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic                        ram_we;
    logic [slr_pkg::EVENT_W-1:0] ram_wdata, ev;
    logic [5:0]                  ev_target;
    logic [7:0]                  ev_val, strobe_pos;
    logic                        lit;

    function automatic logic [7:0] move_pos(input logic [7:0] pos, input logic [3:0] nib);
        logic signed [9:0] t;
        t = $signed({2'b00, pos}) - 10'($signed(nib));
        if (t < 0) begin
            t = t + 10'(slr_pkg::LINE_PIXELS);
        end else if (t >= 10'(slr_pkg::LINE_PIXELS)) begin
            t = t - 10'(slr_pkg::LINE_PIXELS);
        end
        return t[7:0];
    endfunction

    function automatic logic player_lit(input logic [7:0] x, input logic [7:0] pos,
                                        input logic [7:0] gfx);
        logic signed [9:0] d;
        logic              hit;
        hit = 1'b0;
        for (int c = 0; c < slr_pkg::COPY_COUNT; c++) begin
            d = $signed({2'b00, x}) - $signed({2'b00, pos})
                - 10'(c * slr_pkg::COPY_SPACING);
            if (d >= 0 && d < 8 && gfx[3'd7 - d[2:0]]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    assign ram_we    = cmd.store && (count_reg < CW'(DEPTH));
    assign ram_wdata = {s_reg_req, s_value, s_clock_req};

    slr_ram #(
        .WIDTH (slr_pkg::EVENT_W),
        .DEPTH (DEPTH)
    ) u_event_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (cmd.read),
        .raddr (e_reg[AW-1:0]),
        .rdata (ev)
    );

    assign ev_target = ev[21:16];
    assign ev_val    = ev[15:8];

    assign sts.pending = (e_reg < count_reg);
    assign sts.due     = ({1'b0, ev[7:0]} <= (9'(slr_pkg::LINE_START) + {1'b0, cmd.x}));

    assign strobe_pos = cmd.tail ? 8'(slr_pkg::STROBE_TAIL)
                                 : cmd.x + 8'(slr_pkg::STROBE_OFFSET);

    assign lit = player_lit(cmd.x, posa_reg, gsa_reg) || player_lit(cmd.x, posb_reg, gsb_reg);

    always_comb begin
        count_next = count_reg;
        e_next     = e_reg;
        gna_next   = gna_reg;
        gsa_next   = gsa_reg;
        gnb_next   = gnb_reg;
        gsb_next   = gsb_reg;
        dla_next   = dla_reg;
        dlb_next   = dlb_reg;
        posa_next  = posa_reg;
        posb_next  = posb_reg;
        mota_next  = mota_reg;
        motb_next  = motb_reg;
        row_next   = row_reg;

        if (ram_we) begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.rewind) begin
            count_next = '0;
            e_next     = '0;
        end

        if (cmd.apply) begin
            e_next = e_reg + CW'(1);
            case (ev_target)
                slr_pkg::REG_GRAPHIC_A: begin
                    gna_next = ev_val;
                    if (!dla_reg) gsa_next = ev_val;
                    if (dlb_reg) gsb_next = gnb_reg;
                end
                slr_pkg::REG_GRAPHIC_B: begin
                    gnb_next = ev_val;
                    if (!dlb_reg) gsb_next = ev_val;
                    if (dla_reg) gsa_next = gna_reg;
                end
                slr_pkg::REG_DELAY_A:  dla_next  = ev_val[0];
                slr_pkg::REG_DELAY_B:  dlb_next  = ev_val[0];
                slr_pkg::REG_RESET_A:  posa_next = strobe_pos;
                slr_pkg::REG_RESET_B:  posb_next = strobe_pos;
                slr_pkg::REG_MOTION_A: mota_next = ev_val[7:4];
                slr_pkg::REG_MOTION_B: motb_next = ev_val[7:4];
                slr_pkg::REG_MOVE: begin
                    posa_next = move_pos(posa_reg, mota_reg);
                    posb_next = move_pos(posb_reg, motb_reg);
                end
                slr_pkg::REG_MOVE_CLR: begin
                    mota_next = '0;
                    motb_next = '0;
                end
                default: begin
                end
            endcase
        end

        // pixel 0 ends up in bit 0 after the full row is shifted in
        if (cmd.draw) begin
            row_next = {lit, row_reg[ROW_W-1:1]};
        end else if (cmd.shift_out) begin
            row_next = row_reg >> slr_pkg::WORD_W;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            e_reg     <= '0;
            gna_reg   <= '0;
            gsa_reg   <= '0;
            gnb_reg   <= '0;
            gsb_reg   <= '0;
            dla_reg   <= 1'b0;
            dlb_reg   <= 1'b0;
            posa_reg  <= '0;
            posb_reg  <= '0;
            mota_reg  <= '0;
            motb_reg  <= '0;
        end else begin
            count_reg <= count_next;
            e_reg     <= e_next;
            gna_reg   <= gna_next;
            gsa_reg   <= gsa_next;
            gnb_reg   <= gnb_next;
            gsb_reg   <= gsb_next;
            dla_reg   <= dla_next;
            dlb_reg   <= dlb_next;
            posa_reg  <= posa_next;
            posb_reg  <= posb_next;
            mota_reg  <= mota_next;
            motb_reg  <= motb_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg <= row_next;
    end

    assign m_pixels = row_reg[63:0];

    `SLR_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH))
    `SLR_ASSERT_NOW(a_apply_valid, aclk, aresetn, cmd.apply, e_reg < count_reg)
    `SLR_ASSERT_NEXT(a_rewind, aclk, aresetn, cmd.rewind, (count_reg == '0) && (e_reg == '0))

endmodule

FILE: rtl/core/sprite_line_renderer_unit.sv
// sprite line renderer top level joining the sequencer and the datapath
// a buffered write goes into the event memory while it has room, one transaction accepted at a time
// end of line: 160 pixels are drawn before the first word, N writes applied
// during the row and N_tail after it, each a fetch and an apply on the event memory
// then three words, one per cycle while m_ready is high
// synchronous active-low reset empties the buffer and clears all player state
module sprite_line_renderer_unit #(
    parameter int EVENT_DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [5:0]  s_reg_req,
    input  logic [7:0]  s_value,
    input  logic [7:0]  s_clock_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_word_index,
    output logic [63:0] m_pixels,
    output logic        m_last
);

    slr_pkg::cmd_t cmd;
    slr_pkg::sts_t sts;

    slr_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_op         (s_op),
        .s_ready      (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word_index (m_word_index),
        .m_last       (m_last),
        .cmd          (cmd),
        .sts          (sts)
    );

    slr_dp #(
        .DEPTH (EVENT_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_reg_req   (s_reg_req),
        .s_value     (s_value),
        .s_clock_req (s_clock_req),
        .cmd         (cmd),
        .sts         (sts),
        .m_pixels    (m_pixels)
    );

endmodule
